// ===== rtl/xtea_pkg.sv =====
// Shared types and constants of the XTEA block cipher.
`default_nettype none

package xtea_pkg;

   localparam int WORD_W = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int KEY_WORDS = 4;

   localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_3 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECRYPT_MODE = 3'd4;

   typedef logic [WORD_W-1:0] xtea_word_type;

   typedef struct packed {
      xtea_word_type block_high;
      xtea_word_type block_low;
   } xtea_block_type;

   typedef struct packed {
      xtea_word_type result_high;
      xtea_word_type result_low;
   } xtea_result_type;

   typedef struct packed {
      xtea_word_type [KEY_WORDS-1:0] key;
      logic                          decrypt_mode;
   } xtea_cfg_type;

endpackage : xtea_pkg

`default_nettype wire

// ===== rtl/xtea_csr.sv =====
// Configuration registers of the XTEA block cipher: key words and direction.
`default_nettype none

module xtea_csr
   import xtea_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output xtea_cfg_type                cfg
);

   xtea_cfg_type cfg_ff;
   xtea_cfg_type cfg_in;

   // Writes to indexes beyond the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_KEY_WORD_0:   cfg_in.key[0] = csr_wdata[WORD_W-1:0];
            CSR_KEY_WORD_1:   cfg_in.key[1] = csr_wdata[WORD_W-1:0];
            CSR_KEY_WORD_2:   cfg_in.key[2] = csr_wdata[WORD_W-1:0];
            CSR_KEY_WORD_3:   cfg_in.key[3] = csr_wdata[WORD_W-1:0];
            CSR_DECRYPT_MODE: cfg_in.decrypt_mode = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule : xtea_csr

`default_nettype wire

// ===== rtl/xtea_half_round.sv =====
// One registered Feistel half round of XTEA, in either direction.
`default_nettype none

module xtea_half_round
   import xtea_pkg::*;
#(
   parameter logic [31:0] ENC_SUM = 32'h0000_0000,
   parameter logic [31:0] DEC_SUM = 32'h0000_0000,
   parameter bit          ENC_LOW = 1'b1
)
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   input  wire xtea_block_type in_block,
   input  wire xtea_cfg_type   cfg,
   output logic                out_valid,
   output xtea_block_type      out_block
);

   logic           valid_ff;
   xtea_block_type block_ff;
   xtea_block_type block_in;

   logic          upd_low;
   xtea_word_type sum_word;
   xtea_word_type mix_src;
   xtea_word_type target;
   xtea_word_type key_word;
   xtea_word_type feistel;
   xtea_word_type mix_val;
   xtea_word_type updated;
   logic [1:0]    key_sel;

   // The half round that updates the low word picks its key from the two lowest
   // bits of sum, the one that updates the high word from bits 12:11.
   always_comb begin
      upd_low  = ENC_LOW ^ cfg.decrypt_mode;
      sum_word = cfg.decrypt_mode ? DEC_SUM : ENC_SUM;
      mix_src  = upd_low ? in_block.block_high : in_block.block_low;
      target   = upd_low ? in_block.block_low : in_block.block_high;
      key_sel  = upd_low ? sum_word[1:0] : sum_word[12:11];
      key_word = cfg.key[key_sel];
      feistel  = ((mix_src << 4) ^ (mix_src >> 5)) + mix_src;
      mix_val  = feistel ^ (sum_word + key_word);
      updated  = cfg.decrypt_mode ? (target - mix_val) : (target + mix_val);
      block_in = in_block;
      if (upd_low) begin
         block_in.block_low = updated;
      end else begin
         block_in.block_high = updated;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
   end

   assign out_valid = valid_ff;
   assign out_block = block_ff;

endmodule : xtea_half_round

`default_nettype wire

// ===== rtl/xtea_block_cipher.sv =====
// Top level of the XTEA block cipher: key registers and the unrolled round pipeline.
// Throughput: one item per cycle; a new item may start in every cycle outside reset.
// Each half round is one register stage, so the pipeline depth sets the latency.
// Reset is synchronous and active high: it clears the key and direction registers and all valid bits.
// The receiver cannot stall, so results leave with a one-cycle strobe.
`default_nettype none

module xtea_block_cipher
   import xtea_pkg::*;
#(
   parameter int ROUNDS = 32
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire xtea_block_type         req_data,
   output logic                        rsp_strobe,
   output xtea_result_type             rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Every XTEA cycle consists of two half rounds, and each gets a stage.
   localparam int STAGES = 2 * ROUNDS;

   xtea_cfg_type   cfg;
   logic           stage_valid [STAGES+1];
   xtea_block_type stage_block [STAGES+1];

   xtea_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The pipeline never stalls, so the only time an item is refused is while
   // reset is held: nothing would be kept of it.
   assign busy = reset;

   assign stage_valid[0] = start & ~busy;
   assign stage_block[0] = req_data;

   // The sum seen by each stage is a constant per direction. Encryption runs
   // sum upwards from zero; decryption runs it down from delta times ROUNDS.
   // Stage s sits in XTEA cycle s/2. In encryption, even stages update the
   // low word with the sum before the delta step, odd stages the high word
   // with the sum after it; decryption mirrors that, with the high word first.
   // In both directions the sum index works out as (s+1)/2 steps from the start.
   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam logic [63:0] ENC_PROD = 64'((s + 1) / 2) * 64'(XTEA_DELTA);
      localparam logic [63:0] DEC_PROD = 64'(ROUNDS - (s + 1) / 2) * 64'(XTEA_DELTA);

      xtea_half_round #(
         .ENC_SUM (ENC_PROD[31:0]),
         .DEC_SUM (DEC_PROD[31:0]),
         .ENC_LOW ((s % 2) == 0)
      ) u_half_round (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[s]),
         .in_block  (stage_block[s]),
         .cfg       (cfg),
         .out_valid (stage_valid[s+1]),
         .out_block (stage_block[s+1])
      );
   end

   // The last stage register doubles as the output register.
   assign rsp_strobe           = stage_valid[STAGES];
   assign rsp_data.result_low  = stage_block[STAGES].block_low;
   assign rsp_data.result_high = stage_block[STAGES].block_high;

endmodule : xtea_block_cipher

`default_nettype wire

// ===== rtl/xtea_checker.sv =====
// Port-level checker of the XTEA block cipher and its bind to the top level.
`default_nettype none

module xtea_checker
   import xtea_pkg::*;
#(
   parameter int ROUNDS = 32
)
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            start,
   input wire logic            busy,
   input wire logic            rsp_strobe,
   input wire logic            csr_we
);

   localparam int LATENCY = 2 * ROUNDS;

   // Every accepted item comes out exactly after the pipeline depth.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("accepted item did not leave after the pipeline latency");

   // No result appears without an item accepted the pipeline depth earlier.
   assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##LATENCY !rsp_strobe)
      else $error("result strobe without a matching accepted item");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe in the cycle after reset");

   // Out of reset the pipeline takes an item in every cycle.
   assert property (@(posedge clock) disable iff (reset)
      csr_we || !csr_we |-> !busy)
      else $error("busy raised outside reset");

endmodule : xtea_checker

bind xtea_block_cipher xtea_checker #(
   .ROUNDS (ROUNDS)
) u_xtea_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .csr_we     (csr_we)
);

`default_nettype wire

// ===== dv/xtea_cipher_checker.sv =====
// Checker for the XTEA block cipher: watches the ports, predicts each item and compares.
module xtea_cipher_checker
   import xtea_pkg::*;
#(
   parameter int ROUNDS = 32
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  xtea_block_type         req_data,
   input  logic                   rsp_strobe,
   input  xtea_result_type        rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     pending_count,
   output int                     fail_count,
   output int                     checked_count
);

   timeunit 1ns;
   timeprecision 1ps;

   xtea_word_type   key_words_q [KEY_WORDS];
   logic            decrypt_q;
   xtea_result_type blocks_due [$];
   xtea_result_type due_block;
   int              mismatches = 0;
   int              blocks_checked = 0;

   assign fail_count    = mismatches;
   assign checked_count = blocks_checked;

   initial pending_count = 0;

   function automatic xtea_word_type feistel_mix(input xtea_word_type x);
      return ((x << 4) ^ (x >> 5)) + x;
   endfunction

   // Full XTEA on one block with the current key and direction.
   function automatic xtea_result_type xtea_transform(input xtea_block_type blk);
      xtea_word_type   v0;
      xtea_word_type   v1;
      xtea_word_type   sum;
      xtea_result_type res;
      int              r;
      v0 = blk.block_low;
      v1 = blk.block_high;
      if (!decrypt_q) begin
         sum = '0;
         for (r = 0; r < ROUNDS; r++) begin
            v0  = v0 + (feistel_mix(v1) ^ (sum + key_words_q[sum[1:0]]));
            sum = sum + XTEA_DELTA;
            v1  = v1 + (feistel_mix(v0) ^ (sum + key_words_q[sum[12:11]]));
         end
      end else begin
         sum = XTEA_DELTA * xtea_word_type'(ROUNDS);
         for (r = 0; r < ROUNDS; r++) begin
            v1  = v1 - (feistel_mix(v0) ^ (sum + key_words_q[sum[12:11]]));
            sum = sum - XTEA_DELTA;
            v0  = v0 - (feistel_mix(v1) ^ (sum + key_words_q[sum[1:0]]));
         end
      end
      res.result_low  = v0;
      res.result_high = v1;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (key_words_q[i]) key_words_q[i] = '0;
         decrypt_q = 1'b0;
         blocks_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_KEY_WORD_0: key_words_q[0] = csr_wdata;
               CSR_KEY_WORD_1: key_words_q[1] = csr_wdata;
               CSR_KEY_WORD_2: key_words_q[2] = csr_wdata;
               CSR_KEY_WORD_3: key_words_q[3] = csr_wdata;
               CSR_DECRYPT_MODE: decrypt_q = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            if (blocks_due.size() == 0) begin
               $error("result with no item outstanding: result_low %h result_high %h",
                      rsp_data.result_low, rsp_data.result_high);
               mismatches++;
            end else begin
               due_block = blocks_due.pop_front();
               blocks_checked++;
               if (rsp_data.result_low !== due_block.result_low) begin
                  $error("result_low: expected %h, actual %h",
                         due_block.result_low, rsp_data.result_low);
                  mismatches++;
               end
               if (rsp_data.result_high !== due_block.result_high) begin
                  $error("result_high: expected %h, actual %h",
                         due_block.result_high, rsp_data.result_high);
                  mismatches++;
               end
            end
         end
         if (start && !busy) blocks_due.push_back(xtea_transform(req_data));
      end
      pending_count <= blocks_due.size();
   end

endmodule : xtea_cipher_checker

// ===== dv/xtea_block_cipher_test.sv =====
// Top of the XTEA block cipher testbench: clock, reset, stimulus and verdict.
module xtea_block_cipher_test
   import xtea_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROUNDS = 32;
   // The pipeline holds one item per half round, so this is its depth.
   localparam int PIPE_DEPTH = 2 * ROUNDS;
   localparam int RANDOM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 200;

   localparam logic [CSR_DATA_W-1:0] MODE_ENCRYPT = 32'd0;
   localparam logic [CSR_DATA_W-1:0] MODE_DECRYPT = 32'd1;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   xtea_block_type         req_data;
   logic                   rsp_strobe;
   xtea_result_type        rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int pending_count;
   int fail_count;
   int checked_count;
   int items_sent = 0;
   int settings_used = 0;

   always #2 clock = ~clock;

   xtea_block_cipher #(
      .ROUNDS(ROUNDS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // The checker sits beside the block, sees the same ports and keeps its own
   // copy of the key and direction, so the stimulus here never has to predict.
   xtea_cipher_checker #(
      .ROUNDS(ROUNDS)
   ) scoreboard (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .pending_count(pending_count),
      .fail_count(fail_count),
      .checked_count(checked_count)
   );

   // Random half words, biased so that the all-zero and all-one words and
   // sparse or dense single-bit patterns turn up often next to plain noise.
   function automatic xtea_word_type pick_word();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: return '0;
         1: return '1;
         2: return xtea_word_type'(1) << $urandom_range(0, WORD_W - 1);
         3: return ~(xtea_word_type'(1) << $urandom_range(0, WORD_W - 1));
         default: return $urandom();
      endcase
   endfunction

   // One register write, held for a single cycle. The enable is lowered at
   // the following falling edge, so consecutive writes leave a gap between.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Writes all four key words and the direction. Only called while idle.
   task automatic set_config(input xtea_word_type [KEY_WORDS-1:0] key,
                             input logic [CSR_DATA_W-1:0] mode);
      int i;
      for (i = 0; i < KEY_WORDS; i++)
         csr_write(CSR_INDEX_W'(CSR_KEY_WORD_0 + i), key[i]);
      csr_write(CSR_DECRYPT_MODE, mode);
      settings_used++;
   endtask

   // Offers one item, possibly after an idle gap, and returns at the rising
   // edge that accepts it. Start stays high on return, so a following item
   // with no gap is presented in the very next cycle.
   task automatic send_item(input xtea_block_type blk, input int idle_pct);
      int gap;
      gap = 0;
      if ($urandom_range(1, 100) <= idle_pct) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= blk;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_words(input xtea_word_type low, input xtea_word_type high);
      xtea_block_type blk;
      blk.block_low  = low;
      blk.block_high = high;
      send_item(blk, 0);
   endtask

   // Stops offering items and waits for every outstanding result. Since each
   // item gives exactly one result, an empty store means the pipeline is empty.
   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      xtea_word_type [KEY_WORDS-1:0] key;
      xtea_block_type                blk;
      int                            idle_pct;
      int                            pause_at;
      int                            phase;
      int                            n;
      int                            idx;

      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_KEY_WORD_0;
      csr_wdata = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Reset state: all-zero key, encrypting. The extremes of both half
      // words go through back to back with no gaps.
      send_words('0, '0);
      send_words('1, '1);
      send_words('0, '1);
      send_words('1, '0);
      send_words(32'h5555_5555, 32'hAAAA_AAAA);
      send_words(32'h8000_0000, 32'h0000_0001);
      send_words(32'h0000_0001, 32'h8000_0000);
      send_words(32'h0123_4567, 32'h89AB_CDEF);

      // All-ones key and decryption, where sum starts at its top value.
      wait_idle();
      key = '1;
      set_config(key, MODE_DECRYPT);
      send_words('0, '0);
      send_words('1, '1);
      send_words('0, '1);
      send_words('1, '0);
      send_words(32'hDEAD_BEEF, 32'hCAFE_F00D);
      send_words(32'h0000_0001, 32'h0000_0001);

      // Writes to indexes beyond the register list must leave everything
      // alone, and a wide value written to the direction keeps only its low
      // bit: 0xFFFFFFFE therefore selects encryption.
      wait_idle();
      for (idx = CSR_DECRYPT_MODE + 1; idx < (1 << CSR_INDEX_W); idx++)
         csr_write(CSR_INDEX_W'(idx), '1);
      csr_write(CSR_DECRYPT_MODE, 32'hFFFF_FFFE);
      send_words('0, '0);
      send_words('1, '1);
      send_words(32'h1234_5678, 32'h9ABC_DEF0);
      // Odd wide value: decryption, with the ignored writes still ignored.
      wait_idle();
      csr_write(CSR_DECRYPT_MODE, 32'h8000_0003);
      send_words('0, '0);
      send_words('1, '0);
      send_words(32'h0F0F_0F0F, 32'hF0F0_F0F0);

      // Random part: each phase takes a fresh key and direction, then a run
      // of items with its own gap rate. Somewhere in each phase the sender
      // stops until every result is back, so the pipeline also drains and
      // refills from empty mid-phase.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 3)
            0: idle_pct = 0;
            1: idle_pct = 45;
            default: idle_pct = 13;
         endcase
         wait_idle();
         for (n = 0; n < KEY_WORDS; n++) key[n] = pick_word();
         set_config(key, (phase % 2 == 0) ? MODE_ENCRYPT : MODE_DECRYPT);
         pause_at = $urandom_range(20, ITEMS_PER_PHASE - 20);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n == pause_at) wait_idle();
            blk.block_low  = pick_word();
            blk.block_high = pick_word();
            send_item(blk, idle_pct);
         end
      end

      // Drain, then keep the clock running so that any stray strobe can still
      // show up as a result with nothing outstanding.
      wait_idle();
      repeat (PIPE_DEPTH + 8) @(negedge clock);

      $display("Ran %0d items (%0d results checked) under %0d key and direction settings,",
               items_sent, checked_count, settings_used);
      $display("both directions, extreme keys and blocks, ignored register writes and gaps.");
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // A correct run takes well under a hundred microseconds; this only
   // catches a block that stops answering.
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule : xtea_block_cipher_test
